// ===== design/rfp_pkg.sv =====
// rfp_pkg: shared types and constants for the radar frame parser
// frame markers, status codes, update kinds, control/command codes, front-to-back event record, result record
// no dependencies
`default_nettype none

package rfp_pkg;

    // frame markers
    localparam logic [7:0] HDR_0  = 8'h53;
    localparam logic [7:0] HDR_1  = 8'h59;
    localparam logic [7:0] TAIL_0 = 8'h54;
    localparam logic [7:0] TAIL_1 = 8'h43;

    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd64;

    // frame status codes
    localparam logic [2:0] ST_GOOD  = 3'd0;
    localparam logic [2:0] ST_LONG  = 3'd1;
    localparam logic [2:0] ST_CSUM  = 3'd2;
    localparam logic [2:0] ST_TAIL0 = 3'd3;
    localparam logic [2:0] ST_TAIL1 = 3'd4;

    // update kinds
    localparam logic [3:0] KIND_NONE      = 4'd0;
    localparam logic [3:0] KIND_PRESENCE  = 4'd1;
    localparam logic [3:0] KIND_BREATH    = 4'd2;
    localparam logic [3:0] KIND_HEART     = 4'd3;
    localparam logic [3:0] KIND_IN_BED    = 4'd4;
    localparam logic [3:0] KIND_SLEEP     = 4'd5;
    localparam logic [3:0] KIND_HEARTBEAT = 4'd6;
    localparam logic [3:0] KIND_MON_SW    = 4'd7;
    localparam logic [3:0] KIND_RPT_MODE  = 4'd8;
    localparam logic [3:0] KIND_PRODUCT   = 4'd9;

    // control and command codes
    localparam logic [7:0] CTL_HEARTBEAT = 8'h01;
    localparam logic [7:0] CTL_PRODUCT   = 8'h02;
    localparam logic [7:0] CTL_PRESENCE  = 8'h80;
    localparam logic [7:0] CTL_BREATH    = 8'h81;
    localparam logic [7:0] CTL_SLEEP     = 8'h84;
    localparam logic [7:0] CTL_HEART     = 8'h85;
    localparam logic [7:0] CMD_01        = 8'h01;
    localparam logic [7:0] CMD_02        = 8'h02;
    localparam logic [7:0] CMD_80        = 8'h80;
    localparam logic [7:0] CMD_81        = 8'h81;
    localparam logic [7:0] CMD_82        = 8'h82;
    localparam logic [7:0] CMD_8C        = 8'h8C;
    localparam logic [7:0] CMD_A1        = 8'hA1;

    localparam int NUM_SENSORS = 5;
    localparam logic [8:0] SENSOR_RST = 9'h1FF;

    // one ended frame, from the parser to the back end
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  ctrl;
        logic [7:0]  cmd;
        logic [15:0] len;
        logic [7:0]  first;
    } t_rfp_evt;

    // one result as held in the output register
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  kind;
        logic [7:0]  ctrl;
        logic [7:0]  cmd;
        logic [15:0] len;
        logic [31:0] good;
        logic [31:0] bad;
        logic [8:0]  presence;
        logic [8:0]  breath;
        logic [8:0]  heart;
        logic [8:0]  in_bed;
        logic [8:0]  sleep_st;
    } t_rfp_res;

endpackage

`default_nettype wire

// ===== design/rfp_front.sv =====
// rfp_front: byte-serial frame parser, one byte per beat
// emits one event per ended frame; uses rfp_pkg
`default_nettype none

module rfp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wen,
    input  wire logic [15:0]      i_cfg_wdata,
    input  wire logic             i_byte_valid,
    input  wire logic [7:0]       i_byte,
    output rfp_pkg::t_rfp_evt     o_evt,
    output logic                  o_evt_valid
);

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_HDR1  = 4'd1,
        PH_CTRL  = 4'd2,
        PH_CMD   = 4'd3,
        PH_LENH  = 4'd4,
        PH_LENL  = 4'd5,
        PH_DATA  = 4'd6,
        PH_TAIL0 = 4'd7,
        PH_TAIL1 = 4'd8
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_idx, n_idx;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_first, n_first;
    logic [15:0] r_max_payload;

    // next state and frame-end event
    always_comb begin
        n_phase     = r_phase;
        n_ctrl      = r_ctrl;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_first     = r_first;
        o_evt_valid = 1'b0;
        o_evt.status = rfp_pkg::ST_GOOD;
        o_evt.ctrl   = r_ctrl;
        o_evt.cmd    = r_cmd;
        o_evt.len    = r_len;
        o_evt.first  = r_first;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == rfp_pkg::HDR_0) n_phase = PH_HDR1;
            end
            PH_HDR1: begin
                if (i_byte == rfp_pkg::HDR_1) begin
                    n_sum   = rfp_pkg::HDR_0 + rfp_pkg::HDR_1;
                    n_phase = PH_CTRL;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CTRL: begin
                n_ctrl  = i_byte;
                n_sum   = r_sum + i_byte;
                n_phase = PH_CMD;
            end
            PH_CMD: begin
                n_cmd   = i_byte;
                n_sum   = r_sum + i_byte;
                n_phase = PH_LENH;
            end
            PH_LENH: begin
                n_len   = {i_byte, 8'h00};
                n_sum   = r_sum + i_byte;
                n_phase = PH_LENL;
            end
            PH_LENL: begin
                n_len     = {r_len[15:8], i_byte};
                n_sum     = r_sum + i_byte;
                n_idx     = '0;
                o_evt.len = {r_len[15:8], i_byte};
                if ({r_len[15:8], i_byte} > r_max_payload) begin
                    o_evt_valid  = 1'b1;
                    o_evt.status = rfp_pkg::ST_LONG;
                    n_phase      = PH_HUNT;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_idx < r_len) begin
                    if (r_idx == '0) n_first = i_byte;
                    n_idx = r_idx + 16'd1;
                    n_sum = r_sum + i_byte;
                end else if (i_byte != r_sum) begin
                    o_evt_valid  = 1'b1;
                    o_evt.status = rfp_pkg::ST_CSUM;
                    n_phase      = PH_HUNT;
                end else begin
                    n_phase = PH_TAIL0;
                end
            end
            PH_TAIL0: begin
                if (i_byte != rfp_pkg::TAIL_0) begin
                    o_evt_valid  = 1'b1;
                    o_evt.status = rfp_pkg::ST_TAIL0;
                    n_phase      = PH_HUNT;
                end else begin
                    n_phase = PH_TAIL1;
                end
            end
            PH_TAIL1: begin
                o_evt_valid  = 1'b1;
                o_evt.status = (i_byte != rfp_pkg::TAIL_1) ? rfp_pkg::ST_TAIL1
                                                           : rfp_pkg::ST_GOOD;
                n_phase      = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        // nothing moves without a byte
        if (!i_byte_valid) begin
            n_phase     = r_phase;
            n_ctrl      = r_ctrl;
            n_cmd       = r_cmd;
            n_len       = r_len;
            n_idx       = r_idx;
            n_sum       = r_sum;
            n_first     = r_first;
            o_evt_valid = 1'b0;
        end
    end

    // parser state and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_ctrl        <= '0;
            r_cmd         <= '0;
            r_len         <= '0;
            r_idx         <= '0;
            r_sum         <= '0;
            r_first       <= '0;
            r_max_payload <= rfp_pkg::MAX_PAYLOAD_RST;
        end else begin
            r_phase <= n_phase;
            r_ctrl  <= n_ctrl;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
            r_first <= n_first;
            if (i_cfg_wen) r_max_payload <= i_cfg_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== design/rfp_queue.sv =====
// rfp_queue: short event queue between the parser and the back end
// holds rfp_pkg::t_rfp_evt records; uses rfp_pkg
`default_nettype none

module rfp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rfp_pkg::t_rfp_evt i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output rfp_pkg::t_rfp_evt      o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rfp_pkg::t_rfp_evt r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== design/rfp_back.sv =====
// rfp_back: applies ended frames to counters and sensor values
// holds the output register of results; uses rfp_pkg
`default_nettype none

module rfp_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_evt_valid,
    input  wire rfp_pkg::t_rfp_evt i_evt,
    output logic                   o_pop,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output rfp_pkg::t_rfp_res      o_res
);

    logic [31:0] r_good, n_good;
    logic [31:0] r_bad, n_bad;
    logic [8:0]  r_sensor [rfp_pkg::NUM_SENSORS];
    logic [8:0]  n_sensor [rfp_pkg::NUM_SENSORS];
    logic [3:0]  w_kind;
    logic        r_res_valid;
    rfp_pkg::t_rfp_res r_res;

    // sensor update kind from control/command pair
    function automatic logic [3:0] kind_of(input logic [7:0] c, input logic [7:0] m,
                                           input logic has_data);
        logic [3:0] k;
        k = rfp_pkg::KIND_NONE;
        if (has_data) begin
            if (c == rfp_pkg::CTL_PRESENCE &&
                (m == rfp_pkg::CMD_01 || m == rfp_pkg::CMD_81))
                k = rfp_pkg::KIND_PRESENCE;
            else if (c == rfp_pkg::CTL_BREATH &&
                     (m == rfp_pkg::CMD_02 || m == rfp_pkg::CMD_82))
                k = rfp_pkg::KIND_BREATH;
            else if (c == rfp_pkg::CTL_HEART &&
                     (m == rfp_pkg::CMD_02 || m == rfp_pkg::CMD_82))
                k = rfp_pkg::KIND_HEART;
            else if (c == rfp_pkg::CTL_SLEEP &&
                     (m == rfp_pkg::CMD_01 || m == rfp_pkg::CMD_81))
                k = rfp_pkg::KIND_IN_BED;
            else if (c == rfp_pkg::CTL_SLEEP &&
                     (m == rfp_pkg::CMD_02 || m == rfp_pkg::CMD_82))
                k = rfp_pkg::KIND_SLEEP;
            else if (c == rfp_pkg::CTL_HEARTBEAT &&
                     (m == rfp_pkg::CMD_01 || m == rfp_pkg::CMD_80))
                k = rfp_pkg::KIND_HEARTBEAT;
            else if (m == rfp_pkg::CMD_80 &&
                     (c == rfp_pkg::CTL_PRESENCE || c == rfp_pkg::CTL_BREATH ||
                      c == rfp_pkg::CTL_SLEEP || c == rfp_pkg::CTL_HEART))
                k = rfp_pkg::KIND_MON_SW;
            else if (c == rfp_pkg::CTL_SLEEP && m == rfp_pkg::CMD_8C)
                k = rfp_pkg::KIND_RPT_MODE;
            else if (c == rfp_pkg::CTL_PRODUCT &&
                     (m == rfp_pkg::CMD_01 || m == rfp_pkg::CMD_A1))
                k = rfp_pkg::KIND_PRODUCT;
        end
        return k;
    endfunction

    // take an event when the output register is free or being drained
    assign o_pop       = i_evt_valid && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // counter and sensor updates for the event at the queue head
    always_comb begin
        n_good   = r_good;
        n_bad    = r_bad;
        n_sensor = r_sensor;
        w_kind   = rfp_pkg::KIND_NONE;
        if (o_pop) begin
            if (i_evt.status == rfp_pkg::ST_GOOD) begin
                n_good = r_good + 32'd1;
                w_kind = kind_of(i_evt.ctrl, i_evt.cmd, i_evt.len != '0);
                unique case (w_kind)
                    rfp_pkg::KIND_PRESENCE: n_sensor[0] = {1'b0, i_evt.first};
                    rfp_pkg::KIND_BREATH:   n_sensor[1] = {1'b0, i_evt.first};
                    rfp_pkg::KIND_HEART:    n_sensor[2] = {1'b0, i_evt.first};
                    rfp_pkg::KIND_IN_BED:   n_sensor[3] = {1'b0, i_evt.first};
                    rfp_pkg::KIND_SLEEP:    n_sensor[4] = {1'b0, i_evt.first};
                    default: ;
                endcase
            end else begin
                n_bad = r_bad + 32'd1;
            end
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good      <= '0;
            r_bad       <= '0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < rfp_pkg::NUM_SENSORS; i++) begin
                r_sensor[i] <= rfp_pkg::SENSOR_RST;
            end
        end else begin
            r_good   <= n_good;
            r_bad    <= n_bad;
            r_sensor <= n_sensor;
            if (o_pop) r_res_valid <= 1'b1;
            else if (i_res_ready) r_res_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.status   <= i_evt.status;
            r_res.kind     <= w_kind;
            r_res.ctrl     <= i_evt.ctrl;
            r_res.cmd      <= i_evt.cmd;
            r_res.len      <= i_evt.len;
            r_res.good     <= n_good;
            r_res.bad      <= n_bad;
            r_res.presence <= n_sensor[0];
            r_res.breath   <= n_sensor[1];
            r_res.heart    <= n_sensor[2];
            r_res.in_bed   <= n_sensor[3];
            r_res.sleep_st <= n_sensor[4];
        end
    end

endmodule

`default_nettype wire

// ===== design/radar_frame_parser.sv =====
// radar_frame_parser: top level of the sensor frame deframer
// instantiates rfp_front, rfp_queue and rfp_back; uses rfp_pkg
//
//  channel   | direction | beat content
//  s_axis    | in        | tdata[7:0] rx_byte
//  m_axis    | out       | tdata: frame fields, counters, sensor values; tuser: status, kind
//  cfg       | in        | wdata[15:0] max_payload, written when wen is high
//
// one byte per cycle while s_axis_tready is high; a frame result goes from its last byte
// through the parser, then the event queue of QUEUE_DEPTH entries, then the output register
// s_axis_tready drops only when the event queue is full, i.e. when results
// back up behind a stalled m_axis for QUEUE_DEPTH+1 frames
// synchronous active-low reset; max_payload resets to 64, sensor values to -1
`default_nettype none

module radar_frame_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wen,
    input  wire logic [15:0]  i_cfg_wdata,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // [7:0] rx_byte
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [7:0] frame_ctrl, [15:8] frame_cmd, [31:16] payload_len,
    // [63:32] good_frames, [95:64] bad_frames, [104:96] presence,
    // [113:105] breath_rate, [122:114] heart_rate, [131:123] in_bed,
    // [140:132] sleep_state, [143:141] zero
    output logic [143:0]      o_m_axis_tdata,
    output logic [6:0]        o_m_axis_tuser    // [2:0] status, [6:3] update_kind
);

    rfp_pkg::t_rfp_evt w_evt_in;
    rfp_pkg::t_rfp_evt w_evt_out;
    rfp_pkg::t_rfp_res w_res;
    logic w_evt_in_valid;
    logic w_q_full;
    logic w_q_valid;
    logic w_pop;
    logic w_byte_acc;

    assign o_s_axis_tready = !w_q_full;
    assign w_byte_acc      = i_s_axis_tvalid && o_s_axis_tready;

    // parser
    rfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_byte_valid (w_byte_acc),
        .i_byte       (i_s_axis_tdata),
        .o_evt        (w_evt_in),
        .o_evt_valid  (w_evt_in_valid)
    );

    // event queue
    rfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_evt_in_valid),
        .i_data  (w_evt_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_evt_out)
    );

    // counters, sensor values and output register
    rfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (w_q_valid),
        .i_evt       (w_evt_out),
        .o_pop       (w_pop),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (w_res)
    );

    // pack the result beat
    assign o_m_axis_tdata = {3'b000, w_res.sleep_st, w_res.in_bed, w_res.heart,
                             w_res.breath, w_res.presence, w_res.bad, w_res.good,
                             w_res.len, w_res.cmd, w_res.ctrl};
    assign o_m_axis_tuser = {w_res.kind, w_res.status};

    // a frame-end event never meets a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_evt_in_valid |-> !w_q_full)
        else $error("event pushed into full queue");

    // rejected frames carry no update kind
    a_bad_no_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_res.status != rfp_pkg::ST_GOOD))
            |-> (w_res.kind == rfp_pkg::KIND_NONE))
        else $error("rejected frame with update kind");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a popped event always leaves a result in the output register
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_m_axis_tvalid)
        else $error("popped event without result");

endmodule

`default_nettype wire
